// File: rtl/mdp_pkg.sv
// Shared constants, widths and log table for the Magnus dew point block.
package mdp_pkg;

   localparam int TEMP_W = 11;
   localparam int HUM_W = 10;
   localparam int DEW_W = 11;

   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH = 4;

   // Magnus coefficients in scaled integer form
   localparam int B_X1000 = 18678;
   localparam int C_X100 = 25714;
   localparam int PCT_SCALE = 100;
   localparam int TENTHS = 10;

   // Q30 log datapath
   localparam int LOG_Q = 30;
   localparam int LOG_STEPS = 14;
   localparam int EXP_W = 4;
   localparam int ACC_W = 33;
   localparam int M_W = 31;
   localparam int RDEN_W = 22;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [32:0] LN1000_Q30 = 33'd7417145753;

   // round(ln(1 + 2^-k) * 2^30)
   function automatic logic [28:0] ln_step(input int k);
      logic [28:0] v;
      case (k)
         1: v = 29'd435364845;
         2: v = 29'd239598564;
         3: v = 29'd126468572;
         4: v = 29'd65095192;
         5: v = 29'd33040817;
         6: v = 29'd16647494;
         7: v = 29'd8356010;
         8: v = 29'd4186133;
         9: v = 29'd2095107;
         10: v = 29'd1048064;
         11: v = 29'd524160;
         12: v = 29'd262112;
         13: v = 29'd131064;
         14: v = 29'd65534;
         default: v = '0;
      endcase
      return v;
   endfunction

   // width of the classified item passed from front to back
   function automatic int item_w(input int frac);
      return 1 + ACC_W + M_W + 1 + (frac + 25) + RDEN_W;
   endfunction

endpackage

// File: rtl/mdp_ifs.sv
// Valid/ready channel interfaces for sample and result beats.
interface mdp_req_if;
   import mdp_pkg::*;
   logic valid;
   logic ready;
   logic signed [TEMP_W-1:0] temperature_tenths;
   logic [HUM_W-1:0] humidity_tenths;
   modport source(output valid, temperature_tenths, humidity_tenths, input ready);
   modport sink(input valid, temperature_tenths, humidity_tenths, output ready);
endinterface

interface mdp_rsp_if;
   import mdp_pkg::*;
   logic valid;
   logic ready;
   logic signed [DEW_W-1:0] dew_point_tenths;
   logic humidity_error;
   modport source(output valid, dew_point_tenths, humidity_error, input ready);
   modport sink(input valid, dew_point_tenths, humidity_error, output ready);
endinterface

// File: rtl/mdp_front.sv
// Front stage: accepts sample beats and classifies them for the back pipeline.
module mdp_front #(
   parameter int FRAC_BITS = mdp_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mdp_req_if.sink req_ch,
   output logic push_valid,
   input  logic push_ready,
   output logic [mdp_pkg::item_w(FRAC_BITS)-1:0] push_item
);
   import mdp_pkg::*;

   localparam int NUM_W = FRAC_BITS + 25;

   typedef struct packed {
      logic err;
      logic [ACC_W-1:0] acc0;
      logic [M_W-1:0] m;
      logic t_neg;
      logic [NUM_W-1:0] num;
      logic [RDEN_W-1:0] den;
   } item_type;

   logic fv_ff;
   item_type item_ff, item_in;

   logic [TEMP_W-1:0] t_raw;
   logic [TEMP_W-1:0] t_abs;
   logic [EXP_W-1:0] e;
   logic [24:0] prod;
   logic [16:0] base;

   assign req_ch.ready = !fv_ff || push_ready;

   always_comb begin
      t_raw = req_ch.temperature_tenths;
      e = '0;
      for (int b = 0; b < HUM_W; b++) begin
         if (req_ch.humidity_tenths[b]) begin
            e = EXP_W'(b);
         end
      end
      t_abs = t_raw[TEMP_W-1] ? (TEMP_W'(0) - t_raw) : t_raw;
      prod = 25'(t_abs) * 25'(B_X1000);
      base = 17'(C_X100) + {{(17-TEMP_W){t_raw[TEMP_W-1]}}, t_raw} * 17'(TENTHS);
      item_in.err = (req_ch.humidity_tenths == '0);
      item_in.acc0 = ACC_W'(e) * ACC_W'(LN2_Q30);
      item_in.m = M_W'(req_ch.humidity_tenths) << (5'(LOG_Q) - 5'(e));
      item_in.t_neg = t_raw[TEMP_W-1];
      item_in.num = {prod, {FRAC_BITS{1'b0}}};
      item_in.den = RDEN_W'(base[15:0]) * RDEN_W'(PCT_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (req_ch.ready) begin
         fv_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = fv_ff;
   assign push_item = item_ff;
endmodule

// File: rtl/mdp_queue.sv
// Short FIFO between the front and back parts.
module mdp_queue #(
   parameter int W = 8,
   parameter int DEPTH = mdp_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  logic [W-1:0] push_data,
   output logic pop_valid,
   input  logic pop_ready,
   output logic [W-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// File: rtl/mdp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module mdp_div #(
   parameter int NW = 32,
   parameter int DW = 16,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic v_ff [QW];
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [SW-1:0] side_ff [QW];

   // quotient is known to fit QW bits, so the upper dividend part is below the divisor
   logic [NW+DW-1:0] num_ext;
   assign num_ext = {{DW{1'b0}}, in_num} >> QW;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic src_v;
      logic [DW-1:0] src_rem, src_den;
      logic [QW-1:0] src_lo, src_quo;
      logic [SW-1:0] src_side;
      logic [DW:0] trial, diff;
      logic ge;

      if (i == 0) begin : g_first
         assign src_v = in_valid;
         assign src_rem = num_ext[DW-1:0];
         assign src_lo = in_num[QW-1:0];
         assign src_quo = '0;
         assign src_den = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_v = v_ff[i-1];
         assign src_rem = rem_ff[i-1];
         assign src_lo = lo_ff[i-1];
         assign src_quo = quo_ff[i-1];
         assign src_den = den_ff[i-1];
         assign src_side = side_ff[i-1];
      end

      assign trial = {src_rem, src_lo[QW-1]};
      assign ge = (trial >= {1'b0, src_den});
      assign diff = trial - {1'b0, src_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= src_v;
         end
         if (en) begin
            rem_ff[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            lo_ff[i] <= src_lo << 1;
            quo_ff[i] <= {src_quo[QW-2:0], ge};
            den_ff[i] <= src_den;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quo = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];
endmodule

// File: rtl/mdp_back.sv
// Back pipeline: ratio divide, log normalization, residual divide, gamma, dew divide.
module mdp_back #(
   parameter int FRAC_BITS = mdp_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [mdp_pkg::item_w(FRAC_BITS)-1:0] pop_item,
   mdp_rsp_if.source rsp_ch
);
   import mdp_pkg::*;

   localparam int NUM_W = FRAC_BITS + 25;
   localparam int RQ_W = FRAC_BITS + 4;
   localparam int R_W = FRAC_BITS + 5;
   localparam int SHIFT = LOG_Q - FRAC_BITS;
   localparam int LN_W = FRAC_BITS + 4;
   localparam int G_W = FRAC_BITS + 6;
   localparam int N2_W = FRAC_BITS + 20;
   localparam int D2_W = FRAC_BITS + 9;
   localparam int DQ_W = 12;
   localparam int RES_QW = 20;
   localparam int RES_NW = RES_QW + 1 + LOG_Q;
   localparam int LQ_W = ACC_W + 2;
   localparam int SA_W = 1 + ACC_W + M_W + 1;
   localparam int SR_W = 1 + ACC_W + R_W;
   localparam logic [G_W:0] BQ =
      (G_W+1)'((longint'(B_X1000) * (longint'(1) << FRAC_BITS) + 64'sd500) / 64'sd1000);
   localparam logic [LQ_W-1:0] HALF = LQ_W'(1) << (SHIFT - 1);
   localparam logic [DQ_W-1:0] POS_LIMIT = DQ_W'(1023);
   localparam logic [DQ_W-1:0] NEG_LIMIT = DQ_W'(1024);
   localparam logic [DEW_W-1:0] DEW_MAX = 11'h3FF;
   localparam logic [DEW_W-1:0] DEW_MIN = 11'h400;

   typedef struct packed {
      logic err;
      logic [ACC_W-1:0] acc0;
      logic [M_W-1:0] m;
      logic t_neg;
      logic [NUM_W-1:0] num;
      logic [RDEN_W-1:0] den;
   } item_type;

   item_type item;
   logic en;

   assign item = pop_item;
   assign en = !rsp_ch.valid || rsp_ch.ready;
   assign pop_ready = en;

   // ratio divide
   logic ra_v;
   logic [RQ_W-1:0] ra_q;
   logic [SA_W-1:0] ra_side;

   mdp_div #(.NW(NUM_W), .DW(RDEN_W), .QW(RQ_W), .SW(SA_W)) u_ratio_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(pop_valid), .in_num(item.num), .in_den(item.den),
      .in_side({item.err, item.acc0, item.m, item.t_neg}),
      .out_valid(ra_v), .out_quo(ra_q), .out_side(ra_side)
   );

   logic ra_err, ra_tneg;
   logic [ACC_W-1:0] ra_acc;
   logic [M_W-1:0] ra_m;
   logic [R_W-1:0] ra_mag, ra_ratio;

   assign {ra_err, ra_acc, ra_m, ra_tneg} = ra_side;
   assign ra_mag = {1'b0, ra_q};
   assign ra_ratio = ra_tneg ? (R_W'(0) - ra_mag) : ra_mag;

   // shift-and-add log normalization, one factor per stage
   logic lv_ff [LOG_STEPS];
   logic lerr_ff [LOG_STEPS];
   logic [M_W-1:0] lm_ff [LOG_STEPS];
   logic [M_W-1:0] ly_ff [LOG_STEPS];
   logic [ACC_W-1:0] lacc_ff [LOG_STEPS];
   logic [R_W-1:0] lratio_ff [LOG_STEPS];

   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      logic src_v, src_err;
      logic [M_W-1:0] src_m, src_y;
      logic [ACC_W-1:0] src_acc;
      logic [R_W-1:0] src_ratio;
      logic [M_W:0] trial;
      logic take;

      if (i == 0) begin : g_first
         assign src_v = ra_v;
         assign src_err = ra_err;
         assign src_m = ra_m;
         assign src_y = M_W'(1) << LOG_Q;
         assign src_acc = ra_acc;
         assign src_ratio = ra_ratio;
      end else begin : g_next
         assign src_v = lv_ff[i-1];
         assign src_err = lerr_ff[i-1];
         assign src_m = lm_ff[i-1];
         assign src_y = ly_ff[i-1];
         assign src_acc = lacc_ff[i-1];
         assign src_ratio = lratio_ff[i-1];
      end

      assign trial = {1'b0, src_y} + {1'b0, src_y >> (i + 1)};
      assign take = (trial <= {1'b0, src_m});

      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[i] <= 1'b0;
         end else if (en) begin
            lv_ff[i] <= src_v;
         end
         if (en) begin
            lerr_ff[i] <= src_err;
            lm_ff[i] <= src_m;
            ly_ff[i] <= take ? trial[M_W-1:0] : src_y;
            lacc_ff[i] <= take ? (src_acc + ACC_W'(ln_step(i + 1))) : src_acc;
            lratio_ff[i] <= src_ratio;
         end
      end
   end

   // residual term ((m - y) << 30) / y
   logic [M_W-1:0] lm_last, ly_last, res_gap;
   logic [RES_NW-1:0] res_num;

   assign lm_last = lm_ff[LOG_STEPS-1];
   assign ly_last = ly_ff[LOG_STEPS-1];
   assign res_gap = lm_last - ly_last;
   assign res_num = {res_gap[RES_QW:0], {LOG_Q{1'b0}}};

   logic rs_v;
   logic [RES_QW-1:0] rs_q;
   logic [SR_W-1:0] rs_side;

   mdp_div #(.NW(RES_NW), .DW(M_W), .QW(RES_QW), .SW(SR_W)) u_res_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(lv_ff[LOG_STEPS-1]), .in_num(res_num), .in_den(ly_last),
      .in_side({lerr_ff[LOG_STEPS-1], lacc_ff[LOG_STEPS-1], lratio_ff[LOG_STEPS-1]}),
      .out_valid(rs_v), .out_quo(rs_q), .out_side(rs_side)
   );

   logic rs_err;
   logic [ACC_W-1:0] rs_acc;
   logic [R_W-1:0] rs_ratio;
   assign {rs_err, rs_acc, rs_ratio} = rs_side;

   // c1: ln(RH/100) in Q30
   logic c1_v_ff, c1_err_ff;
   logic [LQ_W-1:0] c1_ln_ff;
   logic [R_W-1:0] c1_ratio_ff;
   // c2: rounded magnitude
   logic c2_v_ff, c2_err_ff, c2_neg_ff;
   logic [LN_W-1:0] c2_mag_ff;
   logic [R_W-1:0] c2_ratio_ff;
   // c3: gamma
   logic c3_v_ff, c3_err_ff;
   logic [G_W-1:0] c3_gamma_ff;
   // c4: dew numerator and divisor
   logic c4_v_ff, c4_err_ff, c4_neg_ff;
   logic [N2_W-1:0] c4_num_ff;
   logic [D2_W-1:0] c4_den_ff;

   logic [LQ_W-1:0] c2_abs, c2_sum, c2_shift;
   logic [G_W-1:0] c3_mag, c3_signed, c3_ratio;
   logic c4_neg;
   logic [G_W-1:0] c4_abs;
   logic [G_W:0] c4_diff;

   always_comb begin
      c2_abs = c1_ln_ff[LQ_W-1] ? (LQ_W'(0) - c1_ln_ff) : c1_ln_ff;
      c2_sum = c2_abs + HALF;
      c2_shift = c2_sum >> SHIFT;
      c3_mag = {2'b00, c2_mag_ff};
      c3_signed = c2_neg_ff ? (G_W'(0) - c3_mag) : c3_mag;
      c3_ratio = {c2_ratio_ff[R_W-1], c2_ratio_ff};
      c4_neg = c3_gamma_ff[G_W-1];
      c4_abs = c4_neg ? (G_W'(0) - c3_gamma_ff) : c3_gamma_ff;
      c4_diff = BQ - {c3_gamma_ff[G_W-1], c3_gamma_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
      end else if (en) begin
         c1_v_ff <= rs_v;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
      end
      if (en) begin
         c1_err_ff <= rs_err;
         c1_ln_ff <= {2'b00, rs_acc} + LQ_W'(rs_q) - LQ_W'(LN1000_Q30);
         c1_ratio_ff <= rs_ratio;
         c2_err_ff <= c1_err_ff;
         c2_neg_ff <= c1_ln_ff[LQ_W-1];
         c2_mag_ff <= c2_shift[LN_W-1:0];
         c2_ratio_ff <= c1_ratio_ff;
         c3_err_ff <= c2_err_ff;
         c3_gamma_ff <= c3_signed + c3_ratio;
         c4_err_ff <= c3_err_ff;
         c4_neg_ff <= c4_neg;
         c4_num_ff <= N2_W'(c4_abs[G_W-2:0]) * N2_W'(C_X100);
         c4_den_ff <= D2_W'(c4_diff) * D2_W'(TENTHS);
      end
   end

   // dew point divide
   logic dw_v;
   logic [DQ_W-1:0] dw_q;
   logic [1:0] dw_side;

   mdp_div #(.NW(N2_W), .DW(D2_W), .QW(DQ_W), .SW(2)) u_dew_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c4_v_ff), .in_num(c4_num_ff), .in_den(c4_den_ff),
      .in_side({c4_err_ff, c4_neg_ff}),
      .out_valid(dw_v), .out_quo(dw_q), .out_side(dw_side)
   );

   // output register: sign, saturation, zero-humidity override
   logic out_v_ff, out_err_ff;
   logic [DEW_W-1:0] out_dew_ff, dew_in;

   always_comb begin
      if (dw_side[1]) begin
         dew_in = '0;
      end else if (!dw_side[0]) begin
         dew_in = (dw_q > POS_LIMIT) ? DEW_MAX : dw_q[DEW_W-1:0];
      end else begin
         dew_in = (dw_q > NEG_LIMIT) ? DEW_MIN : (DEW_W'(0) - dw_q[DEW_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dw_v;
      end
      if (en) begin
         out_dew_ff <= dew_in;
         out_err_ff <= dw_side[1];
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.dew_point_tenths = out_dew_ff;
   assign rsp_ch.humidity_error = out_err_ff;
endmodule

// File: rtl/magnus_dew_point.sv
// Magnus dew point calculator: top level tying front, queue and back pipeline.
// Usage:
//   req_ch carries one sample per beat: temperature_tenths (signed, 0.1 degC)
//   and humidity_tenths (0.1 %RH). rsp_ch returns one beat per sample:
//   dew_point_tenths (signed, 0.1 degC, truncated toward zero, saturated to
//   the 11-bit range) and humidity_error, set with a zero result when the
//   humidity is zero.
// Throughput: one sample per cycle, sustained, while rsp_ch takes results.
// Path: a req_ch beat reaches its rsp_ch beat through the front register,
//   the queue, the ratio divider (FRAC_BITS + 4 stages), 14 log steps, the
//   residual divider (20 stages), 4 gamma stages, the dew divider (12
//   stages) and the output register.
// Stalls: while an rsp_ch result waits and is not taken the back pipeline
//   holds; the front keeps taking beats until the queue fills, then drops req_ch.ready.
// Reset: synchronous, active high; clears all valid flags, no results pending.
module magnus_dew_point #(
   parameter int FRAC_BITS = mdp_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mdp_req_if.sink req_ch,
   mdp_rsp_if.source rsp_ch
);
   import mdp_pkg::*;

   localparam int IW = item_w(FRAC_BITS);

   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [IW-1:0] push_item, pop_item;

   // classify: exponent, mantissa, temperature numerator and divisor
   mdp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
   );

   // decouples front acceptance from back stalls
   mdp_queue #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_item),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_item)
   );

   mdp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
      .rsp_ch(rsp_ch)
   );
endmodule
